FILE: design/tws_pkg.sv
// Package for the timing wheel scheduler: field widths, codes, FSM states,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tws_pkg;

  localparam int SLOTS_DEF   = 32;
  localparam int ENTRIES_DEF = 32;
  localparam int MAX_FIRE    = 32;
  localparam int FIRE_CNT_W  = $clog2(MAX_FIRE + 1);

  localparam int DELAY_W  = 6;
  localparam int HID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int DELAY_N  = 2 ** DELAY_W;
  localparam int INFO_W   = DELAY_W + HID_W;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    OP_REG  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_WIDE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    HS_REG,
    HS_CUR,
    HS_REFILE
  } head_src_t;

  typedef enum logic [1:0] {
    HW_FREE,
    HW_ENTRY,
    HW_NIL
  } head_wsrc_t;

  typedef enum logic [1:0] {
    NA_FREE,
    NA_ENTRY,
    NA_TAIL
  } nxt_addr_t;

  typedef enum logic [1:0] {
    OK_REG,
    OK_FULL,
    OK_FIRE,
    OK_EMPTY
  } out_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REG_RD,
    ST_REG_WR,
    ST_REG_OUT,
    ST_FULL_OUT,
    ST_TK_HEAD,
    ST_TK_LOAD,
    ST_TK_RD,
    ST_TK_FIRE,
    ST_TK_REFILE,
    ST_TK_EMPTY,
    ST_LO_RD,
    ST_LO_CHK,
    ST_LO_LINK,
    ST_TK_ADV
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       head_rd;
    head_src_t  head_src;
    logic       head_wr;
    head_wsrc_t head_wsrc;
    logic       next_rd;
    logic       next_wr;
    nxt_addr_t  next_asrc;
    logic       next_wfree;
    logic       info_rd;
    logic       info_wr;
    logic       pop_free;
    logic       push_free;
    logic       walk_start;
    logic       walk_step;
    logic       tail_load;
    logic       tail_step;
    logic       adv_slot;
    logic       out_load;
    out_kind_t  out_kind;
  } tws_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic pool_empty;
    logic e_nil;
    logic n_zero;
    logic n_max;
    logic nx_nil;
    logic periodic;
    logic out_ok;
  } tws_sts_t;

endpackage

FILE: design/tws_ctrl.sv
// Sequencer for the timing wheel: walks register and tick operations
// step by step and drives datapath commands. Depends on tws_pkg.
`timescale 1ns / 1ps

module tws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tws_pkg::tws_sts_t sts,
  output tws_pkg::tws_cmd_t cmd
);
  import tws_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (sts.in_op == OP_TICK) ? ST_TK_HEAD : ST_REG_RD;
        end
      end
      ST_REG_RD:    state_nxt = sts.pool_empty ? ST_FULL_OUT : ST_REG_WR;
      ST_REG_WR:    state_nxt = ST_REG_OUT;
      ST_REG_OUT:   if (sts.out_ok) state_nxt = ST_IDLE;
      ST_FULL_OUT:  if (sts.out_ok) state_nxt = ST_IDLE;
      ST_TK_HEAD:   state_nxt = ST_TK_LOAD;
      ST_TK_LOAD:   state_nxt = ST_TK_RD;
      ST_TK_RD: begin
        if (sts.e_nil) begin
          state_nxt = sts.n_zero ? ST_TK_EMPTY : ST_TK_ADV;
        end else if (sts.n_max) begin
          state_nxt = ST_LO_RD;
        end else begin
          state_nxt = ST_TK_FIRE;
        end
      end
      ST_TK_FIRE: begin
        if (sts.out_ok) begin
          state_nxt = sts.periodic ? ST_TK_REFILE : ST_TK_RD;
        end
      end
      ST_TK_REFILE: state_nxt = ST_TK_RD;
      ST_TK_EMPTY:  if (sts.out_ok) state_nxt = ST_TK_ADV;
      ST_LO_RD:     state_nxt = ST_LO_CHK;
      ST_LO_CHK:    state_nxt = sts.nx_nil ? ST_LO_LINK : ST_LO_RD;
      ST_LO_LINK:   state_nxt = ST_TK_ADV;
      ST_TK_ADV:    state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_tvalid;
      end
      ST_REG_RD: begin
        if (!sts.pool_empty) begin
          cmd.head_rd   = 1'b1;
          cmd.head_src  = HS_REG;
          cmd.next_rd   = 1'b1;
          cmd.next_asrc = NA_FREE;
        end
      end
      ST_REG_WR: begin
        cmd.head_wr   = 1'b1;
        cmd.head_wsrc = HW_FREE;
        cmd.next_wr   = 1'b1;
        cmd.next_asrc = NA_FREE;
        cmd.info_wr   = 1'b1;
        cmd.pop_free  = 1'b1;
      end
      ST_REG_OUT: begin
        cmd.out_load = sts.out_ok;
        cmd.out_kind = OK_REG;
      end
      ST_FULL_OUT: begin
        cmd.out_load = sts.out_ok;
        cmd.out_kind = OK_FULL;
      end
      ST_TK_HEAD: begin
        cmd.head_rd  = 1'b1;
        cmd.head_src = HS_CUR;
      end
      ST_TK_LOAD: begin
        cmd.walk_start = 1'b1;
        cmd.head_wr    = 1'b1;
        cmd.head_wsrc  = HW_NIL;
      end
      ST_TK_RD: begin
        if (!sts.e_nil) begin
          if (sts.n_max) begin
            cmd.tail_load = 1'b1;
          end else begin
            cmd.next_rd   = 1'b1;
            cmd.next_asrc = NA_ENTRY;
            cmd.info_rd   = 1'b1;
          end
        end
      end
      ST_TK_FIRE: begin
        if (sts.out_ok) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OK_FIRE;
          if (sts.periodic) begin
            cmd.head_rd  = 1'b1;
            cmd.head_src = HS_REFILE;
          end else begin
            cmd.next_wr    = 1'b1;
            cmd.next_asrc  = NA_ENTRY;
            cmd.next_wfree = 1'b1;
            cmd.push_free  = 1'b1;
            cmd.walk_step  = 1'b1;
          end
        end
      end
      ST_TK_REFILE: begin
        cmd.head_wr   = 1'b1;
        cmd.head_wsrc = HW_ENTRY;
        cmd.next_wr   = 1'b1;
        cmd.next_asrc = NA_ENTRY;
        cmd.walk_step = 1'b1;
      end
      ST_TK_EMPTY: begin
        cmd.out_load = sts.out_ok;
        cmd.out_kind = OK_EMPTY;
      end
      ST_LO_RD: begin
        cmd.next_rd   = 1'b1;
        cmd.next_asrc = NA_TAIL;
      end
      ST_LO_CHK: begin
        if (sts.nx_nil) begin
          cmd.head_rd  = 1'b1;
          cmd.head_src = HS_CUR;
        end else begin
          cmd.tail_step = 1'b1;
        end
      end
      ST_LO_LINK: begin
        cmd.next_wr   = 1'b1;
        cmd.next_asrc = NA_TAIL;
        cmd.head_wr   = 1'b1;
        cmd.head_wsrc = HW_ENTRY;
      end
      ST_TK_ADV: begin
        cmd.adv_slot = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/tws_dp.sv
// Datapath of the timing wheel: slot head memory, entry link and info
// memories, free pool head, walk registers and result register. Depends on tws_pkg.
`timescale 1ns / 1ps

module tws_dp #(
  parameter int SLOTS   = tws_pkg::SLOTS_DEF,
  parameter int ENTRIES = tws_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tuser,
  input  logic [tws_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tws_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  tws_pkg::tws_cmd_t                  cmd,
  output tws_pkg::tws_sts_t                  sts
);
  import tws_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int EW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);

  // operation latched from the accepted transfer
  logic [DELAY_W-1:0] delay_r;
  logic               per_r;
  logic [HID_W-1:0]   hid_r;

  logic [SW-1:0] cur_r;
  logic [SW-1:0] slot_r;
  logic [EW-1:0] free_head_r;
  logic [EW-1:0] e_r;
  logic [EW-1:0] t_r;
  logic [FIRE_CNT_W-1:0] n_r;

  // slot heads: valid bit per slot, unwritten slot reads as empty
  logic [EW-1:0]    head_mem [SLOTS];
  logic [SLOTS-1:0] head_vld_r;
  logic [EW-1:0]    head_rd_r;
  logic             head_rdv_r;
  logic [EW-1:0]    head_val;

  // entry links: valid bit per entry, unwritten entry reads as i+1
  logic [EW-1:0]      next_mem [ENTRIES];
  logic [ENTRIES-1:0] next_vld_r;
  logic [EW-1:0]      next_rd_r;

  logic [INFO_W-1:0] info_mem [ENTRIES];
  logic [INFO_W-1:0] info_rd_r;
  logic [DELAY_W-1:0] rd_period;
  logic [HID_W-1:0]   rd_hid;

  logic              out_vld_r;
  status_t           out_status_r;
  logic              out_fired_r;
  logic [HID_W-1:0]  out_id_r;
  logic              out_last_r;

  logic [SW-1:0] dmod [DELAY_N];
  logic [SW:0]   reg_sum, ref_sum;
  logic [SW-1:0] reg_slot, ref_slot, head_ra;
  logic [EW-1:0] head_wd, next_a, next_wd;
  logic          fire_last;

  for (genvar g = 0; g < DELAY_N; g++) begin : g_dmod
    assign dmod[g] = SW'(g % SLOTS);
  end

  // both addends below SLOTS, so one conditional subtract wraps the sum
  assign reg_sum  = {1'b0, cur_r} + {1'b0, dmod[delay_r]};
  assign ref_sum  = {1'b0, cur_r} + {1'b0, dmod[rd_period]};
  assign reg_slot = (reg_sum >= (SW+1)'(SLOTS)) ? SW'(reg_sum - (SW+1)'(SLOTS)) : SW'(reg_sum);
  assign ref_slot = (ref_sum >= (SW+1)'(SLOTS)) ? SW'(ref_sum - (SW+1)'(SLOTS)) : SW'(ref_sum);

  assign head_val  = head_rdv_r ? head_rd_r : NIL;
  assign rd_period = info_rd_r[INFO_W-1:HID_W];
  assign rd_hid    = info_rd_r[HID_W-1:0];

  always_comb begin
    case (cmd.head_src)
      HS_REG:    head_ra = reg_slot;
      HS_CUR:    head_ra = cur_r;
      HS_REFILE: head_ra = ref_slot;
      default:   head_ra = cur_r;
    endcase
  end

  always_comb begin
    case (cmd.head_wsrc)
      HW_FREE:  head_wd = free_head_r;
      HW_ENTRY: head_wd = e_r;
      HW_NIL:   head_wd = NIL;
      default:  head_wd = NIL;
    endcase
  end

  always_comb begin
    case (cmd.next_asrc)
      NA_FREE:  next_a = free_head_r;
      NA_ENTRY: next_a = e_r;
      NA_TAIL:  next_a = t_r;
      default:  next_a = e_r;
    endcase
  end

  assign next_wd = cmd.next_wfree ? free_head_r : head_val;

  // slot head memory
  always_ff @(posedge clk) begin
    if (cmd.head_wr) begin
      head_mem[slot_r] <= head_wd;
    end
    if (cmd.head_rd) begin
      head_rd_r  <= head_mem[head_ra];
      head_rdv_r <= head_vld_r[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
    end else if (cmd.head_wr) begin
      head_vld_r[slot_r] <= 1'b1;
    end
  end

  // entry link memory
  always_ff @(posedge clk) begin
    if (cmd.next_wr) begin
      next_mem[next_a[IW-1:0]] <= next_wd;
    end
    if (cmd.next_rd) begin
      next_rd_r <= next_vld_r[next_a[IW-1:0]] ? next_mem[next_a[IW-1:0]] : next_a + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_vld_r <= '0;
    end else if (cmd.next_wr) begin
      next_vld_r[next_a[IW-1:0]] <= 1'b1;
    end
  end

  // entry period and handler, written when an entry leaves the pool
  always_ff @(posedge clk) begin
    if (cmd.info_wr) begin
      info_mem[free_head_r[IW-1:0]] <= {per_r ? delay_r : DELAY_W'(0), hid_r};
    end
    if (cmd.info_rd) begin
      info_rd_r <= info_mem[e_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      delay_r <= in_tdata[DELAY_W-1:0];
      per_r   <= in_tdata[DELAY_W];
      hid_r   <= in_tdata[DELAY_W+HID_W:DELAY_W+1];
    end
    if (cmd.head_rd) begin
      slot_r <= head_ra;
    end
    if (cmd.walk_start) begin
      e_r <= head_val;
    end else if (cmd.walk_step) begin
      e_r <= next_rd_r;
    end
    if (cmd.tail_load) begin
      t_r <= e_r;
    end else if (cmd.tail_step) begin
      t_r <= next_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      free_head_r <= '0;
      n_r         <= '0;
    end else begin
      if (cmd.adv_slot) begin
        cur_r <= (cur_r == SW'(SLOTS - 1)) ? '0 : cur_r + SW'(1);
      end
      if (cmd.pop_free) begin
        free_head_r <= next_rd_r;
      end else if (cmd.push_free) begin
        free_head_r <= e_r;
      end
      if (cmd.walk_start) begin
        n_r <= '0;
      end else if (cmd.walk_step) begin
        n_r <= n_r + FIRE_CNT_W'(1);
      end
    end
  end

  assign fire_last = (next_rd_r == NIL) || (n_r == FIRE_CNT_W'(MAX_FIRE - 1));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OK_REG: begin
          out_status_r <= (32'(delay_r) > 32'(SLOTS)) ? STAT_WIDE : STAT_OK;
          out_fired_r  <= 1'b0;
          out_id_r     <= '0;
          out_last_r   <= 1'b1;
        end
        OK_FULL: begin
          out_status_r <= STAT_FULL;
          out_fired_r  <= 1'b0;
          out_id_r     <= '0;
          out_last_r   <= 1'b1;
        end
        OK_FIRE: begin
          out_status_r <= STAT_OK;
          out_fired_r  <= 1'b1;
          out_id_r     <= rd_hid;
          out_last_r   <= fire_last;
        end
        default: begin
          out_status_r <= STAT_OK;
          out_fired_r  <= 1'b0;
          out_id_r     <= '0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - STATUS_W - HID_W){1'b0}}, out_id_r, out_status_r};

  assign sts.in_op      = op_t'(in_tuser);
  assign sts.pool_empty = (free_head_r == NIL);
  assign sts.e_nil      = (e_r == NIL);
  assign sts.n_zero     = (n_r == '0);
  assign sts.n_max      = (n_r == FIRE_CNT_W'(MAX_FIRE));
  assign sts.nx_nil     = (next_rd_r == NIL);
  assign sts.periodic   = (rd_period != '0);
  assign sts.out_ok     = !out_vld_r || out_tready;

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_vld_r || out_tready))
    else $error("result loaded over a held result");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (n_r < FIRE_CNT_W'(MAX_FIRE)))
    else $error("tick fired past its limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_free |-> (free_head_r != NIL))
    else $error("entry taken from empty pool");

  a_slot_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv_slot |=> (cur_r != $past(cur_r)))
    else $error("current slot did not advance");

endmodule

FILE: design/timing_wheel_scheduler.sv
// Timing wheel scheduler top level. A register transfer yields one result; a tick
// yields one result per entry fired, or a single result for an empty slot. A slot
// holding more than MAX_FIRE entries fires MAX_FIRE of them and relinks the
// leftover entries. Sink stalls hold the sequence at each result.
// Synchronous active-low reset; valid bits stand in for a clearing pass.
`timescale 1ns / 1ps

module timing_wheel_scheduler #(
  parameter int SLOTS   = tws_pkg::SLOTS_DEF,   // 2..256
  parameter int ENTRIES = tws_pkg::ENTRIES_DEF  // 1..64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tws_pkg::IN_TDATA_W-1:0]  in_tdata,   // delay_ticks[5:0], periodic[6],
                                                      // handler_id[14:7], zero[15]
  input  logic                            in_tuser,   // operation
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tws_pkg::OUT_TDATA_W-1:0] out_tdata,  // status[1:0], fired_id[9:2],
                                                      // zero[15:10]
  output logic                            out_tuser,  // fired
  output logic                            out_tlast   // last
);
  import tws_pkg::*;

  // One item is in flight at a time. The controller accepts a transfer only
  // in its idle state; the result register lets the last result of an item
  // wait for the sink while the next item is accepted.
  //
  // Storage:
  //   slot heads   SLOTS entries, valid bit per slot (empty until written)
  //   entry links  ENTRIES entries, valid bit per entry (free chain at reset)
  //   entry info   period and handler, written when an entry is allocated
  //
  // Tick: detach current slot list, fire newest first up to MAX_FIRE, refile periodic
  // entries at now + period, return one-shots to the pool head, then advance.

  tws_cmd_t cmd;
  tws_sts_t sts;

  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tws_dp #(
    .SLOTS   (SLOTS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: verif/timing_wheel_scheduler_test.sv
// Self-checking testbench for timing_wheel_scheduler: register and tick
// transfers checked against a cycle-free wheel predictor.
// Depends on tws_pkg and the timing_wheel_scheduler RTL.
`timescale 1ns / 1ps

module timing_wheel_scheduler_test;
  import tws_pkg::*;

  localparam int SLOTS   = SLOTS_DEF;
  localparam int ENTRIES = ENTRIES_DEF;
  localparam logic [5:0] NIL = 6'(ENTRIES);
  // quiet cycles after the last result
  localparam int TAIL_CYCLES = 150;

  typedef struct packed {
    status_t    status;
    logic       fired;
    logic [7:0] fired_id;
    logic       last;
  } fire_result_t;

  logic clk;
  logic rst_n      = 1'b0;
  logic in_tvalid  = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // delay_ticks[5:0], periodic[6], handler_id[14:7]
  logic in_tuser   = 1'b0;                // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // status[1:0], fired_id[9:2]
  logic out_tuser;                        // fired
  logic out_tlast;                        // last

  timing_wheel_scheduler #(
    .SLOTS   (SLOTS),
    .ENTRIES (ENTRIES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predictor state: our own copy of the wheel
  logic [4:0] wheel_pos;
  logic [5:0] slot_first  [SLOTS];
  logic [5:0] link_next   [ENTRIES];
  logic [5:0] ent_period  [ENTRIES];
  logic [7:0] ent_handler [ENTRIES];
  logic [5:0] free_top;

  fire_result_t due_fires[$];   // results the block still owes, oldest first
  int  errors = 0;
  bit  calm   = 1'b0;           // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic wheel_reset();
    wheel_pos = '0;
    for (int i = 0; i < SLOTS; i++) slot_first[i] = NIL;
    for (int i = 0; i < ENTRIES; i++) begin
      link_next[i]   = (i + 1 < ENTRIES) ? 6'(i + 1) : NIL;
      ent_period[i]  = '0;
      ent_handler[i] = '0;
    end
    free_top = '0;
  endtask

  // Advance the predictor by one accepted transfer and queue what it causes.
  task automatic predict_wheel(input op_t op, input logic [5:0] dly, input logic per,
                               input logic [7:0] hid);
    int cur;
    int slot;
    int n;
    logic [5:0] e;
    logic [5:0] nx;
    logic [5:0] t;
    if (op == OP_REG) begin
      if (free_top >= ENTRIES) begin
        // pool exhausted: dropped, state untouched
        due_fires.push_back('{STAT_FULL, 1'b0, 8'h00, 1'b1});
      end else begin
        e = free_top;
        free_top = link_next[e];
        slot = (int'(wheel_pos) + int'(dly)) % SLOTS;
        ent_period[e]  = per ? dly : 6'd0;
        ent_handler[e] = hid;
        link_next[e]   = slot_first[slot];
        slot_first[slot] = e;
        due_fires.push_back('{(dly > SLOTS) ? STAT_WIDE : STAT_OK, 1'b0, 8'h00, 1'b1});
      end
    end else begin
      cur = int'(wheel_pos);
      e = slot_first[cur];
      slot_first[cur] = NIL;
      n = 0;
      // newest first; periodic ones go back on the wheel, the rest to the pool
      while (e < ENTRIES && n < MAX_FIRE) begin
        nx = link_next[e];
        due_fires.push_back('{STAT_OK, 1'b1, ent_handler[e], 1'b0});
        n++;
        if (ent_period[e] != 0) begin
          slot = (cur + int'(ent_period[e])) % SLOTS;
          link_next[e] = slot_first[slot];
          slot_first[slot] = e;
        end else begin
          link_next[e] = free_top;
          free_top = e;
        end
        e = nx;
      end
      // overlong list: the rest stays, ahead of anything refiled here
      if (e < ENTRIES) begin
        t = e;
        while (link_next[t] < ENTRIES) t = link_next[t];
        link_next[t] = slot_first[cur];
        slot_first[cur] = e;
      end
      if (n == 0) due_fires.push_back('{STAT_OK, 1'b0, 8'h00, 1'b1});
      else due_fires[due_fires.size() - 1].last = 1'b1;
      wheel_pos = 5'((cur + 1) % SLOTS);
    end
  endtask

  // One input transfer. Called at a rising edge; returns at a rising edge
  // with in_tvalid still high unless a gap followed.
  task automatic send_timer_cmd(input op_t op, input logic [5:0] dly, input logic per,
                                input logic [7:0] hid);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, hid, per, dly};
    do @(posedge clk); while (!in_tready);
    predict_wheel(op, dly, per, hid);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random transfer with the given tick share (percent). True periodic timers
  // are kept rare since they hold their entry for good.
  task automatic random_cmd(input int tick_pct, input bit allow_periodic);
    logic [5:0] dly;
    logic       per;
    if ($urandom_range(0, 99) < tick_pct) begin
      // fields on a tick are don't-care; send garbage in them
      send_timer_cmd(OP_TICK, 6'($urandom), 1'($urandom), 8'($urandom));
    end else begin
      dly = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      per = allow_periodic && ($urandom_range(0, 3) == 0);
      // most periodic requests carry a zero period, which degrades to one-shot
      if (per && $urandom_range(0, 7) != 0) dly = 6'd0;
      send_timer_cmd(OP_REG, dly, per, 8'($urandom));
    end
  endtask

  // Zero delay, zero-period periodic, newest-first order, empty slot,
  // extreme handler ids.
  task automatic test_register_and_fire();
    send_timer_cmd(OP_REG, 6'd0, 1'b0, 8'h00);
    send_timer_cmd(OP_REG, 6'd0, 1'b1, 8'hFF);
    send_timer_cmd(OP_REG, 6'd1, 1'b0, 8'h5A);
    send_timer_cmd(OP_TICK, 6'd0, 1'b0, 8'h00);
    send_timer_cmd(OP_TICK, 6'd0, 1'b0, 8'h00);
    send_timer_cmd(OP_TICK, 6'd0, 1'b0, 8'h00);
  endtask

  // Delay at and beyond the wheel size, period a full turn, short period.
  task automatic test_wide_and_full_turn();
    send_timer_cmd(OP_REG, 6'd63, 1'b0, 8'hA5);
    send_timer_cmd(OP_REG, 6'd33, 1'b0, 8'h3C);
    send_timer_cmd(OP_REG, 6'd32, 1'b0, 8'hC3);
    send_timer_cmd(OP_REG, 6'd32, 1'b1, 8'h96);
    send_timer_cmd(OP_REG, 6'd5, 1'b1, 8'h69);
    send_timer_cmd(OP_REG, 6'd2, 1'b0, 8'h81);
    repeat (4) send_timer_cmd(OP_TICK, 6'd0, 1'b0, 8'h00);
  endtask

  // Ticks carrying all-ones and mixed fields must behave as plain ticks.
  task automatic test_tick_ignores_fields();
    send_timer_cmd(OP_TICK, 6'd63, 1'b1, 8'hFF);
    send_timer_cmd(OP_TICK, 6'd21, 1'b0, 8'h7E);
    send_timer_cmd(OP_TICK, 6'd42, 1'b1, 8'h01);
  endtask

  // Mixed traffic; idling switched off for stretches.
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      random_cmd(($urandom_range(0, 1) == 0) ? 35 : 20, 1'b1);
    end
    calm = 1'b0;
  endtask

  // Fill the pool past its size, then tick long enough to drain a full turn.
  task automatic test_pool_exhaustion();
    for (int i = 0; i < ENTRIES + 8; i++) random_cmd(0, 1'b0);
    for (int i = 0; i < SLOTS + 8; i++) random_cmd(100, 1'b0);
  endtask

  // Receiver: ready with random stalls.
  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    fire_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_fires.size() == 0) begin
        $error("unexpected result: status %0d fired %0b fired_id %0h last %0b",
               out_tdata[1:0], out_tuser, out_tdata[9:2], out_tlast);
        errors++;
      end else begin
        want = due_fires.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
          errors++;
        end
        if (out_tuser !== want.fired) begin
          $error("fired: expected %0b, actual %0b", want.fired, out_tuser);
          errors++;
        end
        if (out_tdata[9:2] !== want.fired_id) begin
          $error("fired_id: expected %0h, actual %0h", want.fired_id, out_tdata[9:2]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    wheel_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_and_fire();
    test_wide_and_full_turn();
    test_tick_ignores_fields();
    test_random_traffic(200);
    test_pool_exhaustion();
    test_random_traffic(200);
    in_tvalid <= 1'b0;

    // drain, then watch for stray results
    guard = 0;
    while (due_fires.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (due_fires.size() != 0) begin
      $error("%0d expected results never arrived", due_fires.size());
      errors++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
